/* rtl/sis_pkg.sv */
// Shared types for the stable insertion sorter.
// No dependencies; used by the cell chain and the top level.
package sis_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast value, shift larger entries right
    logic drain;  // shift every entry one place toward the head
  } ctrl_t;

endpackage : sis_pkg

/* rtl/sis_in_if.sv */
// Input channel of the sorter: valid/ready handshake with value and last.
// Depends on sis_pkg.
interface sis_in_if;
  logic            valid;
  logic            ready;
  sis_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface : sis_in_if

/* rtl/sis_out_if.sv */
// Result channel of the sorter: valid/ready handshake with sorted value and flags.
// Depends on sis_pkg.
interface sis_out_if;
  logic            valid;
  logic            ready;
  sis_pkg::value_t value_res;
  logic            last_res;
  logic            dropped;

  modport source (output valid, output value_res, output last_res, output dropped,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input dropped,
                  output ready);
endinterface : sis_out_if

/* rtl/sis_cell.sv */
// One cell of the insertion chain: holds one sorted entry and its valid bit.
// Depends on sis_pkg.
module sis_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sis_pkg::ctrl_t  ctrl_i,
  input  sis_pkg::value_t din_i,
  input  sis_pkg::value_t left_value_i,
  input  logic            left_valid_i,
  input  logic            left_gt_i,
  input  sis_pkg::value_t right_value_i,
  input  logic            right_valid_i,
  output sis_pkg::value_t value_o,
  output logic            valid_o,
  output logic            gt_o
);

  sis_pkg::value_t value_q, value_d;
  logic            valid_q, valid_d;
  logic            take_left;
  logic            take_new;

  // Entry is strictly greater than the new value: it must move right.
  assign gt_o = valid_q && (value_q > din_i);

  assign take_left = left_valid_i && left_gt_i;
  assign take_new  = left_valid_i && !left_gt_i && (!valid_q || gt_o);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.ins) begin
      if (take_left) begin
        value_d = left_value_i;
        valid_d = 1'b1;
      end else if (take_new) begin
        value_d = din_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.drain) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule : sis_cell

/* rtl/stable_insertion_sorter.sv */
// Top level of the stable insertion sorter: control and the chain of cells.
// Depends on sis_pkg, sis_in_if, sis_out_if and sis_cell.
//
// Usage:
//   in_i carries one signed value per item; last marks the end of a batch.
//   While a batch is being collected, in_i.ready is high and one item is
//   taken every cycle. Every cell compares the new value against its entry
//   at once; entries greater than the value shift one cell right and the
//   value lands in the gap, so equal values keep their arrival order.
//   Items that arrive while all MAX_ITEMS cells are full are dropped and
//   the dropped flag is raised on every result of that batch.
//   After the last item is taken, in_i.ready falls and the chain drains
//   through out_o from its head cell, one result per cycle while out_o.ready
//   is high, smallest first, last_res on the final one. The first result is
//   valid the cycle after the last item is taken.
//   A stall on out_o (ready low) simply holds the chain; the shown result
//   stays put until taken. Input resumes the cycle after the final result
//   is taken.
//   Reset clears all valid bits, the drain state and the drop flag; stored
//   values are not cleared and never reach a result before being written.
module stable_insertion_sorter #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sis_in_if.sink    in_i,
  sis_out_if.source out_o
);

  sis_pkg::value_t cell_value [MAX_ITEMS];
  logic            cell_valid [MAX_ITEMS];
  logic            cell_gt    [MAX_ITEMS];

  sis_pkg::ctrl_t  ctrl;
  logic            drain_q;
  logic            overflow_q;
  logic            full;
  logic            in_accept;
  logic            out_accept;

  // Store is full once the tail cell holds an entry.
  assign full       = cell_valid[MAX_ITEMS-1];
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_accept = out_o.valid && out_o.ready;

  // Collect while not draining; drain only shows the head cell.
  assign in_i.ready = !drain_q;

  assign ctrl.ins   = in_accept && !full;
  assign ctrl.drain = out_accept;

  assign out_o.valid     = drain_q;
  assign out_o.value_res = cell_value[0];
  assign out_o.last_res  = !cell_valid[1];
  assign out_o.dropped   = overflow_q;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    sis_pkg::value_t left_value;
    logic            left_valid;
    logic            left_gt;
    sis_pkg::value_t right_value;
    logic            right_valid;

    // Head cell sees a virtual valid, not-greater neighbor on its left.
    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    // Tail cell pulls in an empty slot when the chain drains.
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    sis_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .din_i        (in_i.value),
      .left_value_i (left_value),
      .left_valid_i (left_valid),
      .left_gt_i    (left_gt),
      .right_value_i(right_value),
      .right_valid_i(right_valid),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q    <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      if (in_accept) begin
        // Drop the item when full, but remember it for the batch.
        if (full) begin
          overflow_q <= 1'b1;
        end
        if (in_i.last) begin
          drain_q <= 1'b1;
        end
      end
      // Final result taken: return to collecting a fresh batch.
      if (out_accept && out_o.last_res) begin
        drain_q    <= 1'b0;
        overflow_q <= 1'b0;
      end
    end
  end

endmodule : stable_insertion_sorter

/* rtl/sis_checker.sv */
// Port-level checks for the stable insertion sorter, bound to its top level.
// Depends on stable_insertion_sorter and its channel interfaces.
module sis_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            in_last_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input sis_pkg::value_t out_value_res_i,
  input logic            out_last_res_i
);

  // Collecting and draining never overlap.
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while results are shown");

  // Accepting the last item starts the drain on the next cycle.
  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> out_valid_i)
    else $error("no result after last item");

  // Taking the final result ends the batch.
  a_batch_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_res_i) |=> (!out_valid_i && in_ready_i))
    else $error("batch did not end after final result");

  // Stalled result holds its value.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_value_res_i)))
    else $error("stalled result changed");

endmodule : sis_checker

bind stable_insertion_sorter sis_checker u_sis_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_last_i      (in_i.last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_res_i(out_o.value_res),
  .out_last_res_i (out_o.last_res)
);

/* verif/stable_insertion_sorter_tb.sv */
// Self-checking testbench for the stable insertion sorter: random and directed batches,
// each checked against a predicted ascending order. Random gaps on both channels.
// Depends on sis_pkg, sis_in_if, sis_out_if and stable_insertion_sorter.
`timescale 1ns / 1ps

module stable_insertion_sorter_tb;

  localparam int unsigned     MaxItems   = 16;
  localparam int unsigned     CycleLimit = 300000;
  localparam int unsigned     DrainWait  = 2 * MaxItems + 8;
  localparam sis_pkg::value_t ValMin     = sis_pkg::value_t'(32'h8000_0000);
  localparam sis_pkg::value_t ValMax     = sis_pkg::value_t'(32'h7fff_ffff);

  // One item on the input channel and one sorted result on the output channel.
  typedef struct packed {
    sis_pkg::value_t value;
    logic            last;
  } batch_item_t;

  typedef struct packed {
    sis_pkg::value_t value;
    logic            last;
    logic            dropped;
  } sorted_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sis_in_if  in_ch ();
  sis_out_if out_ch ();

  stable_insertion_sorter #(
    .MAX_ITEMS(MaxItems)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Items waiting to be driven, and the sorted values still owed by the block.
  batch_item_t  pending_items[$];
  sorted_item_t sorted_due[$];

  // Shadow copy of the sorter: the ordered store and the overflow flag of the
  // batch now being collected.
  sis_pkg::value_t shadow_store[$];
  bit              shadow_overflow = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  bit          failed         = 1'b0;

  // Place one accepted value in the shadow store. A value goes after every
  // entry less than or equal to it, so equal values keep their arrival order.
  // On the last item, queue the whole batch as expected results and empty it.
  task automatic sort_in(input sis_pkg::value_t value, input logic last);
    int unsigned pos;
    begin
      if (shadow_store.size() < MaxItems) begin
        pos = shadow_store.size();
        for (int j = 0; j < shadow_store.size(); j++) begin
          if (shadow_store[j] > value) begin
            pos = j;
            break;
          end
        end
        shadow_store.insert(pos, value);
      end else begin
        // Store full: drop the item, flag the batch.
        shadow_overflow = 1'b1;
      end
      if (last) begin
        for (int k = 0; k < shadow_store.size(); k++) begin
          sorted_due.push_back('{value:   shadow_store[k],
                                 last:    (k == shadow_store.size() - 1),
                                 dropped: shadow_overflow});
        end
        shadow_store.delete();
        shadow_overflow = 1'b0;
      end
    end
  endtask

  task automatic push_item(input sis_pkg::value_t value, input logic last);
    pending_items.push_back('{value: value, last: last});
  endtask

  // Mix of full-range values, a narrow band that yields many duplicates,
  // and the corners of the signed range.
  function automatic sis_pkg::value_t pick_value();
    int unsigned r;
    begin
      r = $urandom_range(99);
      if (r < 50) return sis_pkg::value_t'($urandom);
      if (r < 80) return sis_pkg::value_t'(int'($urandom_range(8)) - 4);
      case ($urandom_range(6))
        0:       return ValMin;
        1:       return ValMin + 1;
        2:       return -1;
        3:       return 0;
        4:       return 1;
        5:       return ValMax - 1;
        default: return ValMax;
      endcase
    end
  endfunction

  // Mostly small batches; some exactly fill the store, some overflow it.
  function automatic int unsigned pick_size();
    int unsigned r;
    begin
      r = $urandom_range(99);
      if (r < 50) return $urandom_range(6, 1);
      if (r < 70) return $urandom_range(MaxItems - 1, 7);
      if (r < 85) return MaxItems;
      return $urandom_range(MaxItems + 6, MaxItems + 1);
    end
  endfunction

  task automatic push_batch(input int unsigned size);
    for (int unsigned i = 0; i < size; i++) push_item(pick_value(), i == size - 1);
  endtask

  // Driver: predict on every accepted item, then present the next pending
  // item unless this cycle is picked as a gap. Hold the item while stalled.
  always @(posedge clk_i) begin : drive_in
    batch_item_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) sort_in(in_ch.value, in_ch.last);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.value <= nxt.value;
          in_ch.last  <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation,
  // then pick ready for the next cycle.
  always @(posedge clk_i) begin : watch_out
    sorted_item_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sorted_due.size() == 0) begin
          $display("%0t: unexpected result value_res %0d last_res %0b dropped %0b",
                   $time, out_ch.value_res, out_ch.last_res, out_ch.dropped);
          failed = 1'b1;
        end else begin
          want = sorted_due.pop_front();
          if (out_ch.value_res !== want.value) begin
            $display("%0t: value_res expected %0d actual %0d",
                     $time, want.value, out_ch.value_res);
            failed = 1'b1;
          end
          if (out_ch.last_res !== want.last) begin
            $display("%0t: last_res expected %0b actual %0b",
                     $time, want.last, out_ch.last_res);
            failed = 1'b1;
          end
          if (out_ch.dropped !== want.dropped) begin
            $display("%0t: dropped expected %0b actual %0b",
                     $time, want.dropped, out_ch.dropped);
            failed = 1'b1;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned size;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a batch of one (most negative value), the signed corners
    // out of order, then an overflow batch whose last item is itself dropped.
    push_item(ValMin, 1'b1);
    push_item(ValMax, 1'b0);
    push_item(ValMin, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b1);
    for (int i = 0; i < MaxItems; i++) push_item(sis_pkg::value_t'(8 - i), 1'b0);
    push_item(ValMax, 1'b1);

    // Random batches in four phases of channel pressure: none, sender gaps,
    // receiver stalls, then both at a lighter rate.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      random_sent = 0;
      while (random_sent < 100) begin
        size = pick_size();
        push_batch(size);
        random_sent += size;
      end
      while (pending_items.size() != 0) @(posedge clk_i);
    end

    // Drain: wait for the last item and all owed results, then give the
    // block time to show any stray result.
    while (pending_items.size() != 0 || in_ch.valid || sorted_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (!failed && sorted_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule : stable_insertion_sorter_tb
